FILE: hw/rtl/numeric_literal_classifier_macros.svh
// Assertion macros used by the classifier checker.
// Each macro expands to one labeled concurrent assertion on clk, off during rst.
`ifndef NUMERIC_LITERAL_CLASSIFIER_MACROS_SVH
`define NUMERIC_LITERAL_CLASSIFIER_MACROS_SVH

// Same-cycle implication.
`define NLC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("numeric literal classifier check failed");

// Next-cycle implication.
`define NLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("numeric literal classifier check failed");

`endif

FILE: hw/rtl/nlc_pkg.sv
`timescale 1ns / 1ps

package nlc_pkg;

  // Result codes
  typedef enum logic [1:0] {
    CLS_INT     = 2'd0,
    CLS_FIXED   = 2'd1,
    CLS_FLOAT   = 2'd2,
    CLS_INVALID = 2'd3
  } class_t;

  // Integer recognizer states
  typedef enum logic [3:0] {
    IS_START = 4'd0,
    IS_ZERO  = 4'd1,
    IS_OCT   = 4'd2,
    IS_HEX   = 4'd3,
    IS_DEC   = 4'd4,
    IS_U     = 4'd5,
    IS_UL    = 4'd6,
    IS_ULL   = 4'd7,
    IS_L     = 4'd8,
    IS_LL    = 4'd9,
    IS_LU    = 4'd10,
    IS_LLU   = 4'd11,
    IS_DEAD  = 4'd12
  } int_state_t;

  // Float-body scanner states
  typedef enum logic [3:0] {
    BS_START = 4'd0,
    BS_ZERO  = 4'd1,
    BS_DECI  = 4'd2,
    BS_DECF  = 4'd3,
    BS_HEXI  = 4'd4,
    BS_HEXF  = 4'd5,
    BS_EXP0  = 4'd6,
    BS_EXPD  = 4'd7,
    BS_DONE  = 4'd8
  } body_state_t;

  // Fixed-point suffix states
  typedef enum logic [2:0] {
    FX_START = 3'd0,
    FX_U     = 3'd1,
    FX_LH    = 3'd2,
    FX_QUAL  = 3'd3,
    FX_DEAD  = 3'd4
  } fix_state_t;

  // Floating suffix states
  typedef enum logic [1:0] {
    FL_START = 2'd0,
    FL_SUF   = 2'd1,
    FL_DEAD  = 2'd2
  } flt_state_t;

  // Scanner result handed to the output stage
  typedef struct packed {
    logic   fire;
    class_t cls;
  } scan_result_t;

  // Character codes
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_UP_H   = 8'h48;
  localparam logic [7:0] CH_UP_K   = 8'h4b;
  localparam logic [7:0] CH_UP_L   = 8'h4c;
  localparam logic [7:0] CH_UP_P   = 8'h50;
  localparam logic [7:0] CH_UP_R   = 8'h52;
  localparam logic [7:0] CH_UP_U   = 8'h55;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_L   = 8'h6c;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_LO_Z   = 8'h7a;
  localparam logic [7:0] CASE_DIFF = 8'h20;

endpackage

FILE: hw/rtl/nlc_scan.sv
`timescale 1ns / 1ps

module nlc_scan import nlc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   char_code,
  input  logic         last_char,
  output scan_result_t result
);

  // Character class helpers
  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_7);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) ? (c - CASE_DIFF) : c;
  endfunction

  int_state_t  int_state, int_state_next;
  body_state_t body_state, body_state_next;
  fix_state_t  fix_state, fix_state_next;
  flt_state_t  flt_state, flt_state_next;
  logic        long_case, long_case_next;

  logic [7:0] up;
  logic       same_long;
  logic       take_entry;
  logic       u_is_l;
  logic       qual;
  logic       lh;

  assign up        = to_upper(char_code);
  assign u_is_l    = (up == CH_UP_L);
  assign same_long = (char_code == (long_case ? CH_LO_L : CH_UP_L));
  assign qual      = (up == CH_UP_K) || (up == CH_UP_R);
  assign lh        = (up == CH_UP_L) || (up == CH_UP_H);

  // Integer recognizer, including suffix letters
  always_comb begin
    int_state_next = IS_DEAD;
    long_case_next = long_case;
    take_entry     = 1'b0;
    case (int_state)
      IS_START: begin
        if (char_code == CH_0) int_state_next = IS_ZERO;
        else if ((char_code >= CH_1) && (char_code <= CH_9)) int_state_next = IS_DEC;
      end
      IS_ZERO: begin
        if ((char_code == CH_LO_X) || (char_code == CH_UP_X)) int_state_next = IS_HEX;
        else if (is_oct(char_code)) int_state_next = IS_OCT;
        else take_entry = 1'b1;
      end
      IS_OCT: begin
        if (is_oct(char_code)) int_state_next = IS_OCT;
        else take_entry = 1'b1;
      end
      IS_HEX: begin
        if (is_hex(char_code)) int_state_next = IS_HEX;
        else take_entry = 1'b1;
      end
      IS_DEC: begin
        if (is_dec(char_code)) int_state_next = IS_DEC;
        else take_entry = 1'b1;
      end
      IS_U: begin
        if (u_is_l) begin
          int_state_next = IS_UL;
          long_case_next = (char_code == CH_LO_L);
        end
      end
      IS_UL: begin
        if (same_long) int_state_next = IS_ULL;
      end
      IS_L: begin
        if (same_long) int_state_next = IS_LL;
        else if (up == CH_UP_U) int_state_next = IS_LU;
      end
      IS_LL: begin
        if (up == CH_UP_U) int_state_next = IS_LLU;
      end
      default: int_state_next = IS_DEAD;
    endcase
    // first suffix letter after the digits
    if (take_entry) begin
      if (up == CH_UP_U) begin
        int_state_next = IS_U;
      end else if (u_is_l) begin
        int_state_next = IS_L;
        long_case_next = (char_code == CH_LO_L);
      end
    end
  end

  // Float-body scanner; once done it stays done
  always_comb begin
    body_state_next = BS_DONE;
    case (body_state)
      BS_START: begin
        if (char_code == CH_0) body_state_next = BS_ZERO;
        else if (is_dec(char_code)) body_state_next = BS_DECI;
        else if (char_code == CH_DOT) body_state_next = BS_DECF;
        else if (up == CH_UP_E) body_state_next = BS_EXP0;
      end
      BS_ZERO: begin
        if (up == CH_UP_X) body_state_next = BS_HEXI;
        else if (is_dec(char_code)) body_state_next = BS_DECI;
        else if (char_code == CH_DOT) body_state_next = BS_DECF;
        else if (up == CH_UP_E) body_state_next = BS_EXP0;
      end
      BS_DECI: begin
        if (is_dec(char_code)) body_state_next = BS_DECI;
        else if (char_code == CH_DOT) body_state_next = BS_DECF;
        else if (up == CH_UP_E) body_state_next = BS_EXP0;
      end
      BS_DECF: begin
        if (is_dec(char_code)) body_state_next = BS_DECF;
        else if (up == CH_UP_E) body_state_next = BS_EXP0;
      end
      BS_HEXI: begin
        if (is_hex(char_code)) body_state_next = BS_HEXI;
        else if (char_code == CH_DOT) body_state_next = BS_HEXF;
        else if (up == CH_UP_P) body_state_next = BS_EXP0;
      end
      BS_HEXF: begin
        if (is_hex(char_code)) body_state_next = BS_HEXF;
        else if (up == CH_UP_P) body_state_next = BS_EXP0;
      end
      BS_EXP0: begin
        if ((char_code == CH_PLUS) || (char_code == CH_MINUS) || is_dec(char_code))
          body_state_next = BS_EXPD;
      end
      BS_EXPD: begin
        if (is_dec(char_code)) body_state_next = BS_EXPD;
      end
      default: body_state_next = BS_DONE;
    endcase
  end

  // Suffix recognizers see every char from the one that ends the body
  always_comb begin
    fix_state_next = fix_state;
    flt_state_next = flt_state;
    if (body_state_next == BS_DONE) begin
      case (fix_state)
        FX_START: begin
          if (up == CH_UP_U) fix_state_next = FX_U;
          else if (lh) fix_state_next = FX_LH;
          else if (qual) fix_state_next = FX_QUAL;
          else fix_state_next = FX_DEAD;
        end
        FX_U: begin
          if (lh) fix_state_next = FX_LH;
          else if (qual) fix_state_next = FX_QUAL;
          else fix_state_next = FX_DEAD;
        end
        FX_LH: fix_state_next = qual ? FX_QUAL : FX_DEAD;
        default: fix_state_next = FX_DEAD;
      endcase
      if ((flt_state == FL_START) && ((up == CH_UP_F) || u_is_l))
        flt_state_next = FL_SUF;
      else
        flt_state_next = FL_DEAD;
    end
  end

  // Classification with priority: integer, fixed, floating, invalid
  always_comb begin
    result.fire = accept && last_char;
    if ((int_state_next != IS_START) && (int_state_next != IS_DEAD))
      result.cls = CLS_INT;
    else if ((body_state_next == BS_DONE) && (fix_state_next == FX_QUAL))
      result.cls = CLS_FIXED;
    else if ((body_state_next != BS_DONE) || (flt_state_next == FL_SUF))
      result.cls = CLS_FLOAT;
    else
      result.cls = CLS_INVALID;
  end

  // State update; the final char of a token returns everything to start
  always_ff @(posedge clk) begin
    if (rst || (accept && last_char)) begin
      int_state  <= IS_START;
      body_state <= BS_START;
      fix_state  <= FX_START;
      flt_state  <= FL_START;
      long_case  <= 1'b0;
    end else if (accept) begin
      int_state  <= int_state_next;
      body_state <= body_state_next;
      fix_state  <= fix_state_next;
      flt_state  <= flt_state_next;
      long_case  <= long_case_next;
    end
  end

endmodule

FILE: hw/rtl/numeric_literal_classifier.sv
`timescale 1ns / 1ps
// Numeric literal classifier.
// Input channel: one character of a preprocessing-number token per item
// (char_code, last_char), handshake char_valid / char_stall.
// Output channel: one number_class item per token (0 integer, 1 fixed-point,
// 2 floating, 3 invalid), handshake class_valid / class_stall.
// Throughput: one character per clock while char_stall is low; the
// recognizer state advances on every accepted item in a single pass of
// logic ahead of the state registers. Output: the class is registered
// and appears in the cycle after the final character of its token is
// accepted. Characters that are not final give no output item.
// Reset: all recognizers go to their start state and the output register
// is emptied; the next accepted character opens a new token.
// Stall: while the output register holds a class that the receiver stalls,
// char_stall is raised and no character is taken; once the class is taken,
// a new character is accepted in the same cycle.
module numeric_literal_classifier import nlc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       class_valid,
  input  logic       class_stall,
  output logic [1:0] number_class
);

  logic         accept;
  scan_result_t result;

  // Stall the input only when the output register is full and held
  assign char_stall = class_valid && class_stall;
  assign accept     = char_valid && !char_stall;

  nlc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .last_char (last_char),
    .result    (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      class_valid <= 1'b0;
    end else if (result.fire) begin
      class_valid <= 1'b1;
    end else if (!class_stall) begin
      class_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.fire) begin
      number_class <= result.cls;
    end
  end

endmodule

FILE: hw/rtl/nlc_checker.sv
`timescale 1ns / 1ps
`include "numeric_literal_classifier_macros.svh"

module nlc_checker (
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_stall,
  input logic       last_char,
  input logic       class_valid,
  input logic       class_stall,
  input logic [1:0] number_class
);

  // Final char of a token always yields a class next cycle
  `NLC_ASSERT_NEXT(a_last_gives_class, char_valid && !char_stall && last_char, class_valid)

  // A non-final char never produces an item on an empty output
  `NLC_ASSERT_NEXT(a_mid_no_class,
    char_valid && !char_stall && !last_char && !class_valid, !class_valid)

  // Input is held back only by a full, stalled output
  `NLC_ASSERT_NOW(a_stall_cause, char_stall, class_valid && class_stall)

  // A stalled class stays put
  `NLC_ASSERT_NEXT(a_class_hold, class_valid && class_stall,
    class_valid && $stable(number_class))

endmodule

bind numeric_literal_classifier nlc_checker u_nlc_checker (.*);

FILE: test/nlc_class_check.sv
`timescale 1ns / 1ps

// Watches both channels of the classifier, predicts the class of every token
// and compares it with the class items that leave the block.
module nlc_class_check import nlc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  input  logic       char_stall,
  input  logic [7:0] char_code,
  input  logic       last_char,
  input  logic       class_valid,
  input  logic       class_stall,
  input  logic [1:0] number_class,
  output int         mismatches,
  output int         waiting,
  output int         compared
);

  // Recognizer state of the token in flight
  int_state_t  int_st;
  body_state_t body_st;
  fix_state_t  fix_st;
  flt_state_t  flt_st;
  logic        low_l;

  // Classes predicted but not yet seen on the output
  class_t class_q[$];

  function automatic logic dec_digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic oct_digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_7;
  endfunction

  function automatic logic hex_digit(logic [7:0] c);
    return dec_digit(c) || (c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F);
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_DIFF : c;
  endfunction

  task automatic clear_token();
    int_st  = IS_START;
    body_st = BS_START;
    fix_st  = FX_START;
    flt_st  = FL_START;
    low_l   = 1'b0;
  endtask

  // First letter of an integer suffix; remembers the case of an L
  task automatic open_suffix(input logic [7:0] c);
    if (to_upper(c) == CH_UP_U) begin
      int_st = IS_U;
    end else if (to_upper(c) == CH_UP_L) begin
      low_l  = (c == CH_LO_L);
      int_st = IS_L;
    end else begin
      int_st = IS_DEAD;
    end
  endtask

  // Advance all recognizers by one character; on the final one, predict
  task automatic take_char(input logic [7:0] c, input logic fin);
    logic [7:0] u;
    logic [7:0] l_match;
    logic       lh;
    logic       qual;
    class_t     cls;
    u       = to_upper(c);
    l_match = low_l ? CH_LO_L : CH_UP_L;
    lh      = (u == CH_UP_L) || (u == CH_UP_H);
    qual    = (u == CH_UP_K) || (u == CH_UP_R);

    // integer recognizer
    case (int_st)
      IS_START: begin
        if (c == CH_0) int_st = IS_ZERO;
        else if (c >= CH_1 && c <= CH_9) int_st = IS_DEC;
        else int_st = IS_DEAD;
      end
      IS_ZERO: begin
        if (u == CH_UP_X) int_st = IS_HEX;
        else if (oct_digit(c)) int_st = IS_OCT;
        else open_suffix(c);
      end
      IS_OCT: if (!oct_digit(c)) open_suffix(c);
      IS_HEX: if (!hex_digit(c)) open_suffix(c);
      IS_DEC: if (!dec_digit(c)) open_suffix(c);
      IS_U: begin
        if (u == CH_UP_L) begin
          low_l  = (c == CH_LO_L);
          int_st = IS_UL;
        end else begin
          int_st = IS_DEAD;
        end
      end
      IS_UL: begin
        if (c == l_match) int_st = IS_ULL;
        else int_st = IS_DEAD;
      end
      IS_L: begin
        if (c == l_match) int_st = IS_LL;
        else if (u == CH_UP_U) int_st = IS_LU;
        else int_st = IS_DEAD;
      end
      IS_LL: begin
        if (u == CH_UP_U) int_st = IS_LLU;
        else int_st = IS_DEAD;
      end
      default: int_st = IS_DEAD;
    endcase

    // float body; once done it stays done for the rest of the token
    if (body_st != BS_DONE) begin
      case (body_st)
        BS_START, BS_ZERO, BS_DECI: begin
          if (body_st == BS_ZERO && u == CH_UP_X) body_st = BS_HEXI;
          else if (body_st == BS_START && c == CH_0) body_st = BS_ZERO;
          else if (dec_digit(c)) body_st = BS_DECI;
          else if (c == CH_DOT) body_st = BS_DECF;
          else if (u == CH_UP_E) body_st = BS_EXP0;
          else body_st = BS_DONE;
        end
        BS_DECF: begin
          if (dec_digit(c)) body_st = BS_DECF;
          else if (u == CH_UP_E) body_st = BS_EXP0;
          else body_st = BS_DONE;
        end
        BS_HEXI: begin
          if (hex_digit(c)) body_st = BS_HEXI;
          else if (c == CH_DOT) body_st = BS_HEXF;
          else if (u == CH_UP_P) body_st = BS_EXP0;
          else body_st = BS_DONE;
        end
        BS_HEXF: begin
          if (hex_digit(c)) body_st = BS_HEXF;
          else if (u == CH_UP_P) body_st = BS_EXP0;
          else body_st = BS_DONE;
        end
        BS_EXP0: begin
          if (c == CH_PLUS || c == CH_MINUS || dec_digit(c)) body_st = BS_EXPD;
          else body_st = BS_DONE;
        end
        BS_EXPD: begin
          if (dec_digit(c)) body_st = BS_EXPD;
          else body_st = BS_DONE;
        end
        default: body_st = BS_DONE;
      endcase
    end

    // suffix recognizers see the character that ended the body and all after
    if (body_st == BS_DONE) begin
      case (fix_st)
        FX_START: begin
          if (u == CH_UP_U) fix_st = FX_U;
          else if (lh) fix_st = FX_LH;
          else if (qual) fix_st = FX_QUAL;
          else fix_st = FX_DEAD;
        end
        FX_U: begin
          if (lh) fix_st = FX_LH;
          else if (qual) fix_st = FX_QUAL;
          else fix_st = FX_DEAD;
        end
        FX_LH: begin
          if (qual) fix_st = FX_QUAL;
          else fix_st = FX_DEAD;
        end
        default: fix_st = FX_DEAD;
      endcase
      if (flt_st == FL_START && (u == CH_UP_F || u == CH_UP_L)) flt_st = FL_SUF;
      else flt_st = FL_DEAD;
    end

    // priority: integer, fixed-point, floating, invalid
    if (fin) begin
      if (int_st != IS_START && int_st != IS_DEAD) cls = CLS_INT;
      else if (body_st == BS_DONE && fix_st == FX_QUAL) cls = CLS_FIXED;
      else if (body_st != BS_DONE || flt_st == FL_SUF) cls = CLS_FLOAT;
      else cls = CLS_INVALID;
      class_q.push_back(cls);
      clear_token();
    end
  endtask

  // Compare the outgoing item first: it can only belong to an earlier token
  always @(posedge clk) begin
    class_t want;
    if (rst) begin
      clear_token();
      class_q.delete();
      mismatches <= 0;
      compared   <= 0;
    end else begin
      if (class_valid && !class_stall) begin
        compared <= compared + 1;
        if (class_q.size() == 0) begin
          mismatches <= mismatches + 1;
          $error("number_class: expected no item, got %0d", number_class);
        end else begin
          want = class_q.pop_front();
          if (number_class !== want) begin
            mismatches <= mismatches + 1;
            $error("number_class: expected %0d, got %0d", want, number_class);
          end
        end
      end
      if (char_valid && !char_stall) take_char(char_code, last_char);
    end
    waiting <= class_q.size();
  end

endmodule

FILE: test/tb_numeric_literal_classifier.sv
`timescale 1ns / 1ps

module tb_numeric_literal_classifier;
  import nlc_pkg::*;

  localparam int CHAR_TARGET  = 900;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 20;

  // digit kinds for the token builder
  localparam int DIG_DEC = 0;
  localparam int DIG_OCT = 1;
  localparam int DIG_HEX = 2;

  // printable range used to corrupt well-formed tokens
  localparam int PRINT_LO = 32;
  localparam int PRINT_HI = 126;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_stall;
  logic [7:0] char_code = 8'h00;
  logic       last_char = 1'b0;
  logic       class_valid;
  logic       class_stall = 1'b0;
  logic [1:0] number_class;

  int mismatches;
  int waiting;
  int compared;

  int idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int cycle_count = 0;
  int chars_sent = 0;
  int tokens_sent = 0;

  // characters of the token being built
  logic [7:0] tok[$];

  numeric_literal_classifier dut (
    .clk,
    .rst,
    .char_valid,
    .char_stall,
    .char_code,
    .last_char,
    .class_valid,
    .class_stall,
    .number_class
  );

  nlc_class_check class_check (
    .clk,
    .rst,
    .char_valid,
    .char_stall,
    .char_code,
    .last_char,
    .class_valid,
    .class_stall,
    .number_class,
    .mismatches,
    .waiting,
    .compared
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d classes outstanding", cycle_count, waiting);
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stalls, plus a long hold when one is asked for
  initial begin
    forever begin
      @(posedge clk);
      if (holds_asked > holds_done) begin
        holds_done++;
        class_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      class_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [7:0] any_case(logic [7:0] up);
    return $urandom_range(1) ? up : (up | CASE_DIFF);
  endfunction

  task automatic add_digits(input int kind, input int n);
    int d;
    repeat (n) begin
      case (kind)
        DIG_DEC: tok.push_back(CH_0 + 8'($urandom_range(9)));
        DIG_OCT: tok.push_back(CH_0 + 8'($urandom_range(7)));
        default: begin
          d = $urandom_range(15);
          if (d < 10) tok.push_back(CH_0 + 8'(d));
          else tok.push_back(any_case(CH_UP_A + 8'(d - 10)));
        end
      endcase
    end
  endtask

  // U / L / UL / LU / LL / ULL / LLU or none; LL pair now and then mixed case
  task automatic add_int_suffix();
    logic [7:0] u_ch;
    logic [7:0] l1;
    logic [7:0] l2;
    u_ch = any_case(CH_UP_U);
    l1   = any_case(CH_UP_L);
    l2   = ($urandom_range(7) == 0) ? (l1 ^ CASE_DIFF) : l1;
    case ($urandom_range(7))
      1: tok.push_back(u_ch);
      2: tok.push_back(l1);
      3: begin tok.push_back(u_ch); tok.push_back(l1); end
      4: begin tok.push_back(l1); tok.push_back(u_ch); end
      5: begin tok.push_back(l1); tok.push_back(l2); end
      6: begin tok.push_back(u_ch); tok.push_back(l1); tok.push_back(l2); end
      7: begin tok.push_back(l1); tok.push_back(l2); tok.push_back(u_ch); end
      default: ;
    endcase
  endtask

  task automatic add_integer();
    case ($urandom_range(2))
      0: begin
        tok.push_back(CH_1 + 8'($urandom_range(8)));
        add_digits(DIG_DEC, $urandom_range(4));
      end
      1: begin
        tok.push_back(CH_0);
        add_digits(DIG_OCT, $urandom_range(4));
      end
      default: begin
        tok.push_back(CH_0);
        tok.push_back(any_case(CH_UP_X));
        add_digits(DIG_HEX, $urandom_range(4));
      end
    endcase
    add_int_suffix();
  endtask

  task automatic add_exponent(input logic [7:0] letter);
    tok.push_back(any_case(letter));
    case ($urandom_range(2))
      0: tok.push_back(CH_PLUS);
      1: tok.push_back(CH_MINUS);
      default: ;
    endcase
    add_digits(DIG_DEC, $urandom_range(2));
  endtask

  // Float body, hex or decimal; every part may come out empty
  task automatic add_body();
    int kind;
    logic [7:0] exp_letter;
    if ($urandom_range(2) == 0) begin
      tok.push_back(CH_0);
      tok.push_back(any_case(CH_UP_X));
      kind       = DIG_HEX;
      exp_letter = CH_UP_P;
    end else begin
      kind       = DIG_DEC;
      exp_letter = CH_UP_E;
    end
    add_digits(kind, $urandom_range(3));
    if ($urandom_range(1)) begin
      tok.push_back(CH_DOT);
      add_digits(kind, $urandom_range(3));
    end
    if ($urandom_range(1)) add_exponent(exp_letter);
  endtask

  // Mostly well-formed tokens of each class, some noise, some corrupted
  task automatic make_token();
    int pick;
    int pos;
    pick = $urandom_range(99);
    if (pick < 30) begin
      add_integer();
    end else if (pick < 55) begin
      add_body();
      if ($urandom_range(1)) tok.push_back(any_case($urandom_range(1) ? CH_UP_F : CH_UP_L));
    end else if (pick < 80) begin
      add_body();
      if ($urandom_range(1)) tok.push_back(any_case(CH_UP_U));
      if ($urandom_range(1)) tok.push_back(any_case($urandom_range(1) ? CH_UP_L : CH_UP_H));
      tok.push_back(any_case($urandom_range(1) ? CH_UP_K : CH_UP_R));
    end else if (pick < 90) begin
      repeat ($urandom_range(5, 1)) tok.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(1)) add_integer();
      else add_body();
      if (tok.size() == 0) tok.push_back(CH_1);
      pos = $urandom_range(tok.size() - 1);
      if ($urandom_range(1)) tok[pos] = 8'($urandom_range(255));
      else tok[pos] = 8'($urandom_range(PRINT_HI, PRINT_LO));
    end
    if (tok.size() == 0) tok.push_back(CH_0);
  endtask

  task automatic send_char(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code  <= c;
    last_char  <= fin;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_token();
    foreach (tok[i]) send_char(tok[i], i == tok.size() - 1);
    tok.delete();
    tokens_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
    send_token();
  endtask

  // Stimulus
  initial begin
    int base;
    int phase_end;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: bare hex prefix, loose bodies, every class, byte extremes
    send_text("0x");
    send_text("08");
    send_text(".");
    send_text("1k");
    send_text("1f");
    send_text("9");
    send_text("0xlu");
    send_text("1e+");
    send_text("7ULL");
    tok.push_back(8'hff);
    send_token();
    tok.push_back(8'h00);
    send_token();

    // random phases: free-running, sender gaps, receiver stalls, both
    base = chars_sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      // long output hold while characters keep coming
      if (phase == 0) holds_asked++;
      phase_end = base + (phase + 1) * CHAR_TARGET / 4;
      while (chars_sent < phase_end) begin
        make_token();
        send_token();
      end
    end
    char_valid <= 1'b0;

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d characters in %0d tokens sent, %0d classes compared",
             chars_sent, tokens_sent, compared);
    $display("phases: free-running, sender gaps, receiver stalls, both; one long output hold");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: numeric_literal_classifier.f
+incdir+hw/rtl
hw/rtl/nlc_pkg.sv
hw/rtl/nlc_scan.sv
hw/rtl/numeric_literal_classifier.sv
hw/rtl/nlc_checker.sv
test/nlc_class_check.sv
test/tb_numeric_literal_classifier.sv
